>>> design/stick_deadzone_arcade_mixer_top_assert.svh
// assertion macros for the drive mixer
`ifndef STICK_DEADZONE_ARCADE_MIXER_TOP_ASSERT_SVH
`define STICK_DEADZONE_ARCADE_MIXER_TOP_ASSERT_SVH

// checked on every clock edge, off while reset is high
`define SDAM_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define SDAM_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sdam_pkg.sv
package sdam_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_GAIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN   = 2'd3;

  localparam logic [6:0] DEADZONE_RESET = 7'd10;
  localparam logic [9:0] GAIN_RESET     = 10'd256;

  // floor(x / 100) as (x * 5243) >> 19, exact for x up to 255 * 127
  localparam logic [12:0] DZ_RECIP = 13'd5243;
  localparam int          DZ_SHIFT = 19;
  localparam logic [8:0]  DZ_FULL  = 9'd255;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic              link_enabled;
    logic [8:0]        dz;
    logic [9:0]        fwd_gain;
    logic [9:0]        steer_gain;
  } cfg_t;

  typedef struct packed {
    logic              idle;
    logic signed [9:0] sx;
    logic signed [9:0] sy;
    logic [3:0]        dpad_rise;
    logic              a_rise;
    logic              x_rise;
    logic              menu_rise;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    AX_IDLE,
    AX_PREP,
    AX_DIV,
    AX_DONE
  } ax_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_MUL,
    BK_MIX
  } bk_state_t;

  function automatic logic [8:0] dz_of(input logic [6:0] pct);
    logic [14:0] x;
    logic [27:0] m;
    x = 15'(pct) * 15'd255;
    m = 28'(x) * 28'(DZ_RECIP);
    return m[27:DZ_SHIFT];
  endfunction

endpackage

>>> design/sdam_axis.sv
module sdam_axis (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic signed [9:0] raw,
  input  logic              invert,
  input  logic [8:0]        dz,
  output logic              done,
  output logic signed [8:0] result
);
  import sdam_pkg::*;

  ax_state_t   state, state_next;
  logic [7:0]  mag8;
  logic        neg;
  logic        zero;
  logic [15:0] rem;
  logic [15:0] dsh;
  logic [7:0]  quo;
  logic [2:0]  cnt;

  logic [9:0]  abs_raw;
  logic [17:0] scaled;
  logic [7:0]  diff;
  logic [7:0]  den;
  logic        fits;

  assign abs_raw = raw[9] ? 10'(-raw) : raw;
  assign scaled  = {abs_raw, 8'd0} - {8'd0, abs_raw};
  assign diff    = 8'({1'b0, mag8} - dz);
  assign den     = 8'(DZ_FULL - dz);
  assign fits    = rem >= dsh;

  always_comb begin
    state_next = state;
    unique case (state)
      AX_IDLE: if (start) state_next = AX_PREP;
      AX_PREP: state_next = AX_DIV;
      AX_DIV:  if (cnt == 3'd7) state_next = AX_DONE;
      AX_DONE: if (start) state_next = AX_PREP;
    endcase
  end

  always_comb begin
    done   = state == AX_DONE;
    result = zero ? 9'sd0 : (neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AX_IDLE;
    end else begin
      state <= state_next;
    end
    if (start) begin
      mag8 <= scaled[16:9];
      neg  <= invert ? (!raw[9] && raw != 10'sd0) : raw[9];
    end
    if (state == AX_PREP) begin
      zero <= ({1'b0, mag8} <= dz) || (dz >= DZ_FULL);
      rem  <= {diff, 8'd0} - {8'd0, diff};
      dsh  <= {1'b0, den, 7'd0};
      quo  <= '0;
      cnt  <= '0;
    end
    if (state == AX_DIV) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[6:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt + 3'd1;
    end
  end

endmodule

>>> design/sdam_fifo.sv
module sdam_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  sdam_pkg::item_t     wr_item,
  input  logic                rd,
  output sdam_pkg::item_t     head,
  output sdam_pkg::q_status_t status
);
  import sdam_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign head         = mem[rptr];
  assign status.empty = count == '0;
  assign status.full  = count == (FIFO_AW+1)'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (rd) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      priority if (wr && !rd) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (FIFO_AW+1)'(1);
      end else begin
        count <= count;
      end
    end
    if (wr) begin
      mem[wptr] <= wr_item;
    end
  end

endmodule

>>> design/sdam_front.sv
module sdam_front (
  input  logic              clk,
  input  logic              rst,
  input  sdam_pkg::cfg_t    cfg,
  input  logic              accept,
  input  logic              pad_present,
  input  logic signed [9:0] stick_x,
  input  logic signed [9:0] stick_y,
  input  logic [3:0]        dpad_bits,
  input  logic              button_a,
  input  logic              button_x,
  input  logic              menu_button,
  output sdam_pkg::item_t   item
);
  import sdam_pkg::*;

  logic [3:0] dpad_prev;
  logic       a_prev;
  logic       x_prev;
  logic       menu_prev;
  logic       idle;

  assign idle = !cfg.link_enabled || !pad_present;

  always_comb begin
    item.idle      = idle;
    item.sx        = stick_x;
    item.sy        = stick_y;
    item.dpad_rise = idle ? 4'd0 : (dpad_bits & ~dpad_prev);
    item.a_rise    = !idle && button_a && !a_prev;
    item.x_rise    = !idle && button_x && !x_prev;
    item.menu_rise = !idle && menu_button && !menu_prev;
  end

  // history clears on a report taken while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      dpad_prev <= '0;
      a_prev    <= 1'b0;
      x_prev    <= 1'b0;
      menu_prev <= 1'b0;
    end else if (accept) begin
      dpad_prev <= idle ? 4'd0 : dpad_bits;
      a_prev    <= !idle && button_a;
      x_prev    <= !idle && button_x;
      menu_prev <= !idle && menu_button;
    end
  end

endmodule

>>> design/sdam_back.sv
module sdam_back (
  input  logic                clk,
  input  logic                rst,
  input  sdam_pkg::cfg_t      cfg,
  input  sdam_pkg::item_t     head,
  input  sdam_pkg::q_status_t q_status,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic signed [8:0]   left_drive,
  output logic signed [8:0]   right_drive,
  output logic [3:0]          dpad_rise,
  output logic                a_rise,
  output logic                x_rise,
  output logic                menu_rise
);
  import sdam_pkg::*;

  bk_state_t         state, state_next;
  logic              start;
  logic              load;
  logic              out_valid;
  logic              idle;
  logic [3:0]        dpad_r;
  logic              a_r;
  logic              x_r;
  logic              menu_r;
  logic signed [19:0] ts;
  logic signed [19:0] ss;

  logic              steer_done;
  logic              thr_done;
  logic signed [8:0] steer;
  logic signed [8:0] thr;
  logic signed [8:0] left_next;
  logic signed [8:0] right_next;

  sdam_axis u_steer (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .raw    (head.sx),
    .invert (1'b0),
    .dz     (cfg.dz),
    .done   (steer_done),
    .result (steer)
  );

  sdam_axis u_thr (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .raw    (head.sy),
    .invert (1'b1),
    .dz     (cfg.dz),
    .done   (thr_done),
    .result (thr)
  );

  function automatic logic signed [8:0] mix(input logic signed [20:0] sum);
    logic signed [20:0] adj;
    logic signed [20:0] q;
    adj = sum + (sum[20] ? 21'sd255 : 21'sd0);
    q   = adj >>> 8;
    priority if (q > 21'sd255) begin
      return 9'sd255;
    end else if (q < -21'sd255) begin
      return -9'sd255;
    end else begin
      return q[8:0];
    end
  endfunction

  assign left_next  = mix(21'(ts) + 21'(ss));
  assign right_next = mix(21'(ts) - 21'(ss));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_status.empty) state_next = BK_RUN;
      BK_RUN:  if (steer_done && thr_done) state_next = BK_MUL;
      BK_MUL:  state_next = BK_MIX;
      BK_MIX:  if (!out_valid || pop) state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    start = 1'b0;
    load  = 1'b0;
    unique case (state)
      BK_IDLE: start = !q_status.empty;
      BK_RUN:  ;
      BK_MUL:  ;
      BK_MIX:  load = !out_valid || pop;
    endcase
    q_rd  = start;
    empty = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      priority if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
    if (start) begin
      idle   <= head.idle;
      dpad_r <= head.dpad_rise;
      a_r    <= head.a_rise;
      x_r    <= head.x_rise;
      menu_r <= head.menu_rise;
    end
    if (state == BK_MUL) begin
      ts <= $signed(thr) * $signed({1'b0, cfg.fwd_gain});
      ss <= $signed(steer) * $signed({1'b0, cfg.steer_gain});
    end
    if (load) begin
      left_drive  <= idle ? 9'sd0 : left_next;
      right_drive <= idle ? 9'sd0 : right_next;
      dpad_rise   <= dpad_r;
      a_rise      <= a_r;
      x_rise      <= x_r;
      menu_rise   <= menu_r;
    end
  end

endmodule

>>> design/stick_deadzone_arcade_mixer_top.sv
// channel   | beat taken when     | carries
// ----------+---------------------+------------------------------------------------
// report in | push && !full       | pad_present, stick_x, stick_y, dpad_bits, buttons
// drive out | pop && !empty       | left_drive, right_drive, dpad_rise, a/x/menu_rise
// config    | cfg_write           | cfg_index, cfg_data
//
// each report's result is worked out by the
// 8-step restoring divider in each axis unit (both axes run side by side)
// one report is worked at a time; a two-entry queue keeps accepting reports
// while the back end computes or a finished result waits to be popped
// rst is synchronous; it empties the queue, drops the result and restores
// the config defaults with no clearing pass
module stick_deadzone_arcade_mixer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           pad_present,
  input  logic signed [9:0]              stick_x,
  input  logic signed [9:0]              stick_y,
  input  logic [3:0]                     dpad_bits,
  input  logic                           button_a,
  input  logic                           button_x,
  input  logic                           menu_button,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [8:0]              left_drive,
  output logic signed [8:0]              right_drive,
  output logic [3:0]                     dpad_rise,
  output logic                           a_rise,
  output logic                           x_rise,
  output logic                           menu_rise,
  input  logic                           cfg_write,
  input  logic [sdam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdam_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdam_pkg::*;

  cfg_t      cfg;
  item_t     fe_item;
  item_t     q_head;
  q_status_t q_status;
  logic      accept;
  logic      q_rd;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_enabled <= 1'b1;
      cfg.dz           <= dz_of(DEADZONE_RESET);
      cfg.fwd_gain     <= GAIN_RESET;
      cfg.steer_gain   <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINK_ENABLED: cfg.link_enabled <= cfg_data[0];
        REG_DEADZONE_PCT: cfg.dz           <= dz_of(cfg_data[6:0]);
        REG_FWD_GAIN:     cfg.fwd_gain     <= cfg_data;
        REG_STEER_GAIN:   cfg.steer_gain   <= cfg_data;
      endcase
    end
  end

  sdam_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .pad_present (pad_present),
    .stick_x     (stick_x),
    .stick_y     (stick_y),
    .dpad_bits   (dpad_bits),
    .button_a    (button_a),
    .button_x    (button_x),
    .menu_button (menu_button),
    .item        (fe_item)
  );

  sdam_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_item (fe_item),
    .rd      (q_rd),
    .head    (q_head),
    .status  (q_status)
  );

  sdam_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (q_head),
    .q_status    (q_status),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .dpad_rise   (dpad_rise),
    .a_rise      (a_rise),
    .x_rise      (x_rise),
    .menu_rise   (menu_rise)
  );

endmodule

>>> design/sdam_checker.sv
`include "stick_deadzone_arcade_mixer_top_assert.svh"

module sdam_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic signed [8:0] left_drive,
  input logic signed [8:0] right_drive,
  input logic [3:0]        dpad_rise,
  input logic              a_rise,
  input logic              x_rise,
  input logic              menu_rise
);

  `SDAM_CHECK_ALWAYS(a_reset_clears, rst |=> empty && !full, "reset left a result or a full queue")

  `SDAM_CHECK(a_drive_range, !empty |-> left_drive != 9'h100 && right_drive != 9'h100, "drive out of range")

  `SDAM_CHECK(a_hold, !empty && !pop |=> !empty && $stable(left_drive) && $stable(right_drive) && $stable({dpad_rise, a_rise, x_rise, menu_rise}), "waiting beat changed")

endmodule

bind stick_deadzone_arcade_mixer_top sdam_checker u_sdam_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .left_drive  (left_drive),
  .right_drive (right_drive),
  .dpad_rise   (dpad_rise),
  .a_rise      (a_rise),
  .x_rise      (x_rise),
  .menu_rise   (menu_rise)
);
